>>> rtl/ion_zone_allocator_assert.svh
// assertion macros shared by the ion zone allocator modules
`ifndef ION_ZONE_ALLOCATOR_ASSERT_SVH
`define ION_ZONE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IZA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IZA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iza_pkg.sv
// types and constants shared by the ion zone allocator
package iza_pkg;

    localparam int LOC_W      = 3;
    localparam int TYPE_ZONES = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // zone type bits
    localparam logic [5:0] T_LOAD    = 6'h01;
    localparam logic [5:0] T_EMPTY   = 6'h02;
    localparam logic [5:0] T_STORAGE = 6'h04;
    localparam logic [5:0] T_GATE    = 6'h08;
    localparam logic [5:0] T_COOL    = 6'h10;
    localparam logic [5:0] T_MEASURE = 6'h20;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_LOAD  = 2'd1;
    localparam logic [1:0] ST_NO_WORK  = 2'd2;
    localparam logic [1:0] ST_NO_STORE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ION_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_TYPES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_CAPS  = 2'd3;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    typedef struct packed {
        logic       command;
        logic [2:0] op_class;
        logic [1:0] target_count;
        logic [3:0] first_target;
        logic [3:0] second_target;
        logic [3:0] third_target;
    } iza_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       has_ion;
        logic [3:0] ion;
        logic [2:0] work_zone;
        logic [2:0] final_zone;
        logic       last;
    } iza_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WORK,
        S_READ,
        S_MOVE,
        S_STORE,
        S_COMMIT,
        S_LCHECK,
        S_LWRITE
    } iza_state_t;

    typedef enum logic [1:0] {
        SRCH_LOAD,
        SRCH_WORK,
        SRCH_STORE
    } iza_srch_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_LOAD_FAIL,
        EMIT_LOAD_OK,
        EMIT_NO_WORK,
        EMIT_NO_TGT,
        EMIT_TARGET
    } iza_emit_t;

    typedef struct packed {
        logic      start;
        logic      idx_inc;
        logic      idx_clr;
        logic      work_latch;
        logic      rd;
        logic      move;
        logic      store;
        logic      commit_wr;
        logic      occ_commit;
        logic      ld_init;
        logic      ld_place;
        logic      ld_write;
        logic      clr_valid;
        iza_srch_t srch;
        iza_emit_t emit;
    } iza_cmd_t;

    typedef struct packed {
        logic in_exec;
        logic found;
        logic cnt_zero;
        logic idx_last;
        logic idx_end;
        logic store_fail;
        logic can_emit;
    } iza_sts_t;

endpackage

>>> rtl/iza_dpath.sv
// datapath: configuration, occupancy table, zone search, ion location memory, result register
`include "ion_zone_allocator_assert.svh"

module iza_dpath #(
    parameter int MAX_ZONES   = 8,
    parameter int MAX_IONS    = 16,
    parameter int MAX_TARGETS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  iza_pkg::iza_in_t                   in_data,
    input  logic                               out_stall,
    output logic                               out_valid,
    output iza_pkg::iza_out_t                  out_data,
    input  logic                               cfg_valid,
    input  logic [iza_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iza_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  iza_pkg::iza_cmd_t                  cmd,
    output iza_pkg::iza_sts_t                  sts
);

    localparam int ZIW  = $clog2(MAX_ZONES);
    localparam int IXW  = (MAX_IONS > 1) ? $clog2(MAX_IONS) : 1;
    localparam int TIW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CMAX = (MAX_IONS > MAX_TARGETS) ? MAX_IONS : MAX_TARGETS;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int NLW  = $clog2(MAX_IONS + 1);
    localparam int TCW  = $clog2(MAX_TARGETS + 1);
    localparam int LW   = iza_pkg::LOC_W;

    // configuration
    logic [3:0]  zone_count_reg;
    logic [4:0]  ion_count_reg;
    logic [47:0] zone_types_reg;
    logic [31:0] zone_caps_reg;

    // occupancy
    logic [3:0] occ_reg  [MAX_ZONES];
    logic [3:0] occ_work [MAX_ZONES];
    logic [3:0] occ_upd  [MAX_ZONES];

    // item
    logic             item_cmd_reg;
    logic [2:0]       item_cls_reg;
    logic [TCW-1:0]   item_cnt_reg;
    logic [IXW-1:0]   tgt_reg [MAX_TARGETS];
    logic [IXW-1:0]   tgt_in  [MAX_TARGETS];
    logic [IXW-1:0]   mod_tab [16];
    logic [TCW-1:0]   cnt_in;

    logic [CW-1:0]    idx_reg;
    logic [TIW-1:0]   slot;
    logic [IXW-1:0]   tgt_cur;
    logic [ZIW-1:0]   wz_reg;
    logic             failed_reg;
    logic [LW-1:0]    pend_loc [MAX_TARGETS];
    logic [NLW-1:0]   n_load;

    // location memory
    logic [LW-1:0]       loc_mem [MAX_IONS];
    logic [MAX_IONS-1:0] valid_reg;
    logic [LW-1:0]       rd_loc_reg;
    logic                rd_valid_reg;
    logic [LW-1:0]       mem_loc_cur;
    logic                wr_en;
    logic [IXW-1:0]      wr_addr;
    logic [LW-1:0]       wr_data;

    // search
    logic [5:0]           srch_mask;
    logic [MAX_ZONES-1:0] elig;
    logic                 srch_found;
    logic [ZIW-1:0]       srch_zone;

    logic          move_hit;
    logic [LW-1:0] move_cur;
    logic [LW-1:0] store_cur;

    logic          dec_en;
    logic [LW-1:0] dec_zone;
    logic          inc_en;
    logic [ZIW-1:0] inc_zone;

    logic               out_valid_reg;
    iza_pkg::iza_out_t  out_data_reg;
    iza_pkg::iza_out_t  out_data_next;
    logic               can_emit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_count_reg <= 4'd8;
            ion_count_reg  <= 5'd1;
            zone_types_reg <= '0;
            zone_caps_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                iza_pkg::CFG_ZONE_COUNT: zone_count_reg <= cfg_data[3:0];
                iza_pkg::CFG_ION_COUNT:  ion_count_reg  <= cfg_data[4:0];
                iza_pkg::CFG_ZONE_TYPES: zone_types_reg <= cfg_data[47:0];
                iza_pkg::CFG_ZONE_CAPS:  zone_caps_reg  <= cfg_data[31:0];
            endcase
        end
    end

    assign n_load = (32'(ion_count_reg) > MAX_IONS) ? NLW'(MAX_IONS) : NLW'(ion_count_reg);

    // target index reduction table
    for (genvar v = 0; v < 16; v++)
    begin : g_mod
        localparam int MODV = v % MAX_IONS;
        assign mod_tab[v] = IXW'(MODV);
    end

    for (genvar s = 0; s < MAX_TARGETS; s++)
    begin : g_tgt_in
        if (s == 0)
        begin : g_first
            assign tgt_in[s] = mod_tab[in_data.first_target];
        end
        else if (s == 1)
        begin : g_second
            assign tgt_in[s] = mod_tab[in_data.second_target];
        end
        else if (s == 2)
        begin : g_third
            assign tgt_in[s] = mod_tab[in_data.third_target];
        end
        else
        begin : g_none
            assign tgt_in[s] = '0;
        end
    end

    assign cnt_in = (32'(in_data.target_count) > MAX_TARGETS) ? TCW'(MAX_TARGETS)
                                                              : TCW'(in_data.target_count);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_cmd_reg <= in_data.command;
            item_cls_reg <= in_data.op_class;
            item_cnt_reg <= cnt_in;
            tgt_reg      <= tgt_in;
        end
    end

    assign slot    = idx_reg[TIW-1:0];
    assign tgt_cur = tgt_reg[slot];

    // zone search, first fit
    always_comb
    begin
        unique case (cmd.srch)
            iza_pkg::SRCH_LOAD:  srch_mask = iza_pkg::T_LOAD;
            iza_pkg::SRCH_STORE: srch_mask = iza_pkg::T_STORAGE | iza_pkg::T_EMPTY;
            iza_pkg::SRCH_WORK:
            begin
                priority if (item_cls_reg[0]) srch_mask = iza_pkg::T_GATE;
                else if (item_cls_reg[1])     srch_mask = iza_pkg::T_COOL;
                else if (item_cls_reg[2])     srch_mask = iza_pkg::T_MEASURE;
                else                          srch_mask = '0;
            end
            default: srch_mask = '0;
        endcase
    end

    for (genvar z = 0; z < MAX_ZONES; z++)
    begin : g_zone
        if (z < iza_pkg::TYPE_ZONES)
        begin : g_typed
            localparam logic [3:0] ZID = 4'(z);
            assign elig[z] = (ZID < zone_count_reg)
                          && (|(zone_types_reg[6*z +: 6] & srch_mask))
                          && (occ_work[z] < zone_caps_reg[4*z +: 4]);
        end
        else
        begin : g_untyped
            assign elig[z] = 1'b0;
        end
    end

    always_comb
    begin
        srch_found = 1'b0;
        srch_zone  = '0;
        for (int z = MAX_ZONES - 1; z >= 0; z--)
        begin
            if (elig[z])
            begin
                srch_found = 1'b1;
                srch_zone  = ZIW'(z);
            end
        end
    end

    // current location of the target, seen through this item's earlier moves
    assign mem_loc_cur = rd_valid_reg ? rd_loc_reg : '0;

    always_comb
    begin
        move_hit = 1'b0;
        for (int s = 0; s < MAX_TARGETS; s++)
        begin
            if (s < int'(idx_reg) && tgt_reg[s] == tgt_cur)
                move_hit = 1'b1;
        end
    end

    assign move_cur = move_hit ? LW'(wz_reg) : mem_loc_cur;

    always_comb
    begin
        store_cur = LW'(wz_reg);
        for (int s = 0; s < MAX_TARGETS; s++)
        begin
            if (s < int'(idx_reg) && tgt_reg[s] == tgt_cur)
                store_cur = pend_loc[s];
        end
    end

    // occupancy update: one decrement and one increment, both saturating
    always_comb
    begin
        dec_en   = 1'b0;
        dec_zone = '0;
        inc_en   = 1'b0;
        inc_zone = '0;
        priority if (cmd.move)
        begin
            dec_en   = 1'b1;
            dec_zone = move_cur;
            inc_en   = 1'b1;
            inc_zone = wz_reg;
        end
        else if (cmd.store && srch_found)
        begin
            dec_en   = 1'b1;
            dec_zone = store_cur;
            inc_en   = 1'b1;
            inc_zone = srch_zone;
        end
        else if (cmd.ld_place)
        begin
            inc_en   = 1'b1;
            inc_zone = srch_zone;
        end
    end

    always_comb
    begin
        for (int z = 0; z < MAX_ZONES; z++)
        begin
            occ_upd[z] = occ_work[z];
            if (dec_en && int'(dec_zone) == z && occ_upd[z] != 4'd0)
                occ_upd[z] = occ_upd[z] - 4'd1;
            if (inc_en && int'(inc_zone) == z && occ_upd[z] != 4'd15)
                occ_upd[z] = occ_upd[z] + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int z = 0; z < MAX_ZONES; z++)
                occ_work[z] <= (in_data.command == iza_pkg::CMD_EXEC) ? occ_reg[z] : 4'd0;
        end
        else if (cmd.ld_init)
        begin
            occ_work <= '{default: '0};
        end
        else if (dec_en || inc_en)
        begin
            occ_work <= occ_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '{default: '0};
        else if (cmd.occ_commit)
            occ_reg <= occ_work;
    end

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start || cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + CW'(1);

            if (cmd.start)
                failed_reg <= 1'b0;
            else if (cmd.store && !srch_found)
                failed_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.work_latch)
            wz_reg <= srch_zone;
        if (cmd.store)
            pend_loc[slot] <= srch_found ? LW'(srch_zone) : store_cur;
    end

    // location memory, one write and one registered read
    assign wr_en   = cmd.ld_write || cmd.commit_wr;
    assign wr_addr = cmd.ld_write ? idx_reg[IXW-1:0] : tgt_cur;
    assign wr_data = cmd.ld_write ? LW'(srch_zone) : pend_loc[slot];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            loc_mem[wr_addr] <= wr_data;
        if (cmd.rd)
        begin
            rd_loc_reg   <= loc_mem[tgt_cur];
            rd_valid_reg <= valid_reg[tgt_cur];
        end
    end

    // entries not valid read as zone 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.clr_valid)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_addr] <= 1'b1;
    end

    // result word
    always_comb
    begin
        out_data_next = '0;
        unique case (cmd.emit)
            iza_pkg::EMIT_NONE: out_data_next = '0;
            iza_pkg::EMIT_LOAD_FAIL:
            begin
                out_data_next.status = iza_pkg::ST_NO_LOAD;
                out_data_next.ion    = 4'(idx_reg);
                out_data_next.last   = 1'b1;
            end
            iza_pkg::EMIT_LOAD_OK:
            begin
                out_data_next.status = iza_pkg::ST_OK;
                out_data_next.last   = 1'b1;
            end
            iza_pkg::EMIT_NO_WORK:
            begin
                out_data_next.status = iza_pkg::ST_NO_WORK;
                out_data_next.last   = 1'b1;
            end
            iza_pkg::EMIT_NO_TGT:
            begin
                out_data_next.status    = iza_pkg::ST_OK;
                out_data_next.work_zone = 3'(srch_zone);
                out_data_next.last      = 1'b1;
            end
            iza_pkg::EMIT_TARGET:
            begin
                out_data_next.status     = srch_found ? iza_pkg::ST_OK : iza_pkg::ST_NO_STORE;
                out_data_next.has_ion    = 1'b1;
                out_data_next.ion        = 4'(tgt_cur);
                out_data_next.work_zone  = 3'(wz_reg);
                out_data_next.final_zone = srch_found ? 3'(srch_zone) : 3'(store_cur);
                out_data_next.last       = sts.idx_last;
            end
            default: out_data_next = '0;
        endcase
    end

    assign can_emit = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit != iza_pkg::EMIT_NONE)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != iza_pkg::EMIT_NONE)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to the controller
    assign sts.in_exec    = (in_data.command == iza_pkg::CMD_EXEC);
    assign sts.found      = srch_found;
    assign sts.cnt_zero   = (item_cnt_reg == '0);
    assign sts.idx_last   = (idx_reg == (CW'(item_cnt_reg) - CW'(1)));
    assign sts.idx_end    = (idx_reg == CW'(n_load));
    assign sts.store_fail = failed_reg || !srch_found;
    assign sts.can_emit   = can_emit;

    `IZA_ASSERT_SAME(a_commit_clean,
        cmd.occ_commit && item_cmd_reg == iza_pkg::CMD_EXEC, !failed_reg,
        "occupancy committed after a failed target move")
    `IZA_ASSERT_SAME(a_place_found, cmd.ld_place, srch_found,
        "ion placed without a load zone")

endmodule

>>> rtl/iza_ctrl.sv
// controller state machine sequencing load and execute commands
`include "ion_zone_allocator_assert.svh"

module iza_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  iza_pkg::iza_sts_t sts,
    output iza_pkg::iza_cmd_t cmd
);

    iza_pkg::iza_state_t state_reg;
    iza_pkg::iza_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iza_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            iza_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.in_exec ? iza_pkg::S_WORK : iza_pkg::S_LCHECK;
                end
            end
            iza_pkg::S_WORK:
            begin
                cmd.srch = iza_pkg::SRCH_WORK;
                if (!sts.found)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit   = iza_pkg::EMIT_NO_WORK;
                        state_next = iza_pkg::S_IDLE;
                    end
                end
                else if (sts.cnt_zero)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit   = iza_pkg::EMIT_NO_TGT;
                        state_next = iza_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.work_latch = 1'b1;
                    state_next     = iza_pkg::S_READ;
                end
            end
            iza_pkg::S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = iza_pkg::S_MOVE;
            end
            // first pass: every target into the work zone
            iza_pkg::S_MOVE:
            begin
                cmd.move = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = iza_pkg::S_STORE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = iza_pkg::S_READ;
                end
            end
            // second pass: each target on to storage, one word per target
            iza_pkg::S_STORE:
            begin
                cmd.srch = iza_pkg::SRCH_STORE;
                if (sts.can_emit)
                begin
                    cmd.store = 1'b1;
                    cmd.emit  = iza_pkg::EMIT_TARGET;
                    if (sts.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = sts.store_fail ? iza_pkg::S_IDLE : iza_pkg::S_COMMIT;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            iza_pkg::S_COMMIT:
            begin
                cmd.commit_wr = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.occ_commit = 1'b1;
                    state_next     = iza_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // dry run of the load placement; only the working occupancy changes until it passes
            iza_pkg::S_LCHECK:
            begin
                cmd.srch = iza_pkg::SRCH_LOAD;
                if (sts.idx_end)
                begin
                    cmd.clr_valid = 1'b1;
                    cmd.ld_init   = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = iza_pkg::S_LWRITE;
                end
                else if (!sts.found)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit   = iza_pkg::EMIT_LOAD_FAIL;
                        state_next = iza_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.ld_place = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            iza_pkg::S_LWRITE:
            begin
                cmd.srch = iza_pkg::SRCH_LOAD;
                if (sts.idx_end)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.occ_commit = 1'b1;
                        cmd.emit       = iza_pkg::EMIT_LOAD_OK;
                        state_next     = iza_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.ld_place = 1'b1;
                    cmd.ld_write = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            default:
            begin
                state_next = iza_pkg::S_IDLE;
            end
        endcase
    end

    `IZA_ASSERT_SAME(a_emit_room, cmd.emit != iza_pkg::EMIT_NONE, sts.can_emit,
        "result word issued while output register is held")
    `IZA_ASSERT_NEXT(a_idle_holds, state_reg == iza_pkg::S_IDLE && !in_valid,
        state_reg == iza_pkg::S_IDLE, "left idle without an input word")
    `IZA_ASSERT_NEXT(a_start_dispatch, cmd.start,
        state_reg == iza_pkg::S_WORK || state_reg == iza_pkg::S_LCHECK,
        "accepted word not dispatched to a command sequence")

endmodule

>>> rtl/ion_zone_allocator.sv
// Ion zone allocator: keeps zone occupancy and ion locations, serves load and execute commands.
//
// Input channel in_valid/in_stall/in_data carries one command word; in_stall is low only
// while the block is idle, so one command is worked at a time. Each command yields one or
// more words on out_valid/out_stall/out_data; the last word of a command has last set.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high
// and writes are meant for idle periods only.
// An execute command picks the work zone, reads the location and makes the first move for
// each target, moves each target on to storage (one word each) and, if all found room,
// writes the locations back. A load walks all ions twice through the first-fit search; the
// shared zone search and the location memory, one write and one read port, keep it serial.
// Reset clears the occupancy table and marks every ion location as zone 0 at once.
// A stalled output word holds in the output register; the sequence waits at the next
// word until it is taken.
module ion_zone_allocator #(
    parameter int MAX_ZONES   = 8,
    parameter int MAX_IONS    = 16,
    parameter int MAX_TARGETS = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  iza_pkg::iza_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output iza_pkg::iza_out_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [iza_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iza_pkg::CFG_DATA_W-1:0] cfg_data
);

    iza_pkg::iza_cmd_t cmd;
    iza_pkg::iza_sts_t sts;

    assign cfg_ready = 1'b1;

    iza_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    iza_dpath #(
        .MAX_ZONES   (MAX_ZONES),
        .MAX_IONS    (MAX_IONS),
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> bench/iza_checker.sv
`timescale 1ns / 100ps
// scoreboard for the ion zone allocator: shadows config and tables, predicts and compares words
module iza_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  iza_pkg::iza_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  iza_pkg::iza_out_t              out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [iza_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iza_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             mismatches
);

    localparam int ZONES   = 8;
    localparam int IONS    = 16;
    localparam int TARGETS = 3;

    logic [3:0]  zone_cnt_r;
    logic [4:0]  ion_cnt_r;
    logic [47:0] zone_types_r;
    logic [31:0] zone_caps_r;

    // occupancy, four bits per zone, and location, three bits per ion
    logic [31:0] occ_table;
    logic [47:0] loc_table;

    iza_pkg::iza_out_t expected_words[$];
    iza_pkg::iza_out_t want;

    // lowest zone in use whose type matches and which has room, -1 if none
    function automatic int first_fit(input logic [31:0] occ, input logic [5:0] mask);
        int n;
        int z;
        n = (int'(zone_cnt_r) > ZONES) ? ZONES : int'(zone_cnt_r);
        first_fit = -1;
        for (z = n - 1; z >= 0; z--)
            if (((zone_types_r[6*z +: 6] & mask) != 6'd0)
                && (occ[4*z +: 4] < zone_caps_r[4*z +: 4]))
                first_fit = z;
    endfunction

    function automatic logic [31:0] occ_inc(input logic [31:0] occ, input int z);
        if (occ[4*z +: 4] != 4'hF)
            occ[4*z +: 4] = occ[4*z +: 4] + 4'd1;
        occ_inc = occ;
    endfunction

    function automatic logic [31:0] occ_dec(input logic [31:0] occ, input int z);
        if (occ[4*z +: 4] != 4'h0)
            occ[4*z +: 4] = occ[4*z +: 4] - 4'd1;
        occ_dec = occ;
    endfunction

    task automatic allocate_cmd(input iza_pkg::iza_in_t w);
        logic [31:0]       occ;
        logic [47:0]       loc;
        logic [3:0]        tgt [3];
        iza_pkg::iza_out_t r;
        logic              failed;
        int                n;
        int                i;
        int                z;
        int                wz;
        int                d;
        int                cnt;
        int                t;
        tgt[0] = w.first_target;
        tgt[1] = w.second_target;
        tgt[2] = w.third_target;
        r = '0;
        r.last = 1'b1;
        failed = 1'b0;
        if (w.command == iza_pkg::CMD_LOAD)
        begin
            n = (int'(ion_cnt_r) > IONS) ? IONS : int'(ion_cnt_r);
            occ = '0;
            loc = '0;
            for (i = 0; i < n && !failed; i++)
            begin
                z = first_fit(occ, iza_pkg::T_LOAD);
                if (z < 0)
                begin
                    failed = 1'b1;
                    r.status = iza_pkg::ST_NO_LOAD;
                    r.ion = i[3:0];
                end
                else
                begin
                    loc[3*i +: 3] = z[2:0];
                    occ = occ_inc(occ, z);
                end
            end
            if (!failed)
            begin
                occ_table = occ;
                loc_table = loc;
            end
            expected_words.push_back(r);
        end
        else
        begin
            occ = occ_table;
            loc = loc_table;
            // only the highest-priority class is searched
            if (w.op_class[0])
                wz = first_fit(occ, iza_pkg::T_GATE);
            else if (w.op_class[1])
                wz = first_fit(occ, iza_pkg::T_COOL);
            else if (w.op_class[2])
                wz = first_fit(occ, iza_pkg::T_MEASURE);
            else
                wz = -1;
            cnt = (int'(w.target_count) > TARGETS) ? TARGETS : int'(w.target_count);
            if (wz < 0)
            begin
                r.status = iza_pkg::ST_NO_WORK;
                expected_words.push_back(r);
            end
            else if (cnt == 0)
            begin
                r.work_zone = wz[2:0];
                expected_words.push_back(r);
            end
            else
            begin
                for (t = 0; t < cnt; t++)
                begin
                    occ = occ_dec(occ, int'(loc[3*tgt[t] +: 3]));
                    occ = occ_inc(occ, wz);
                    loc[3*tgt[t] +: 3] = wz[2:0];
                end
                for (t = 0; t < cnt; t++)
                begin
                    d = first_fit(occ, iza_pkg::T_STORAGE | iza_pkg::T_EMPTY);
                    r.status = iza_pkg::ST_OK;
                    r.has_ion = 1'b1;
                    r.ion = tgt[t];
                    r.work_zone = wz[2:0];
                    if (d < 0)
                    begin
                        r.status = iza_pkg::ST_NO_STORE;
                        failed = 1'b1;
                    end
                    else
                    begin
                        occ = occ_dec(occ, int'(loc[3*tgt[t] +: 3]));
                        occ = occ_inc(occ, d);
                        loc[3*tgt[t] +: 3] = d[2:0];
                    end
                    r.final_zone = loc[3*tgt[t] +: 3];
                    r.last = (t == cnt - 1);
                    expected_words.push_back(r);
                end
                // one stranded target throws away the whole command
                if (!failed)
                begin
                    occ_table = occ;
                    loc_table = loc;
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_cnt_r   = 4'd8;
            ion_cnt_r    = 5'd1;
            zone_types_r = '0;
            zone_caps_r  = '0;
            occ_table    = '0;
            loc_table    = '0;
            mismatches   = 0;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    iza_pkg::CFG_ZONE_COUNT: zone_cnt_r   = cfg_data[3:0];
                    iza_pkg::CFG_ION_COUNT:  ion_cnt_r    = cfg_data[4:0];
                    iza_pkg::CFG_ZONE_TYPES: zone_types_r = cfg_data[47:0];
                    iza_pkg::CFG_ZONE_CAPS:  zone_caps_r  = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %h", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    compare_field("status", int'(want.status), int'(out_data.status));
                    compare_field("has_ion", int'(want.has_ion), int'(out_data.has_ion));
                    compare_field("ion", int'(want.ion), int'(out_data.ion));
                    compare_field("work_zone", int'(want.work_zone),
                                  int'(out_data.work_zone));
                    compare_field("final_zone", int'(want.final_zone),
                                  int'(out_data.final_zone));
                    compare_field("last", int'(want.last), int'(out_data.last));
                end
            end
            if (in_valid && !in_stall)
                allocate_cmd(in_data);
            pending <= expected_words.size();
        end
    end

endmodule

>>> bench/tb_ion_zone_allocator.sv
`timescale 1ns / 100ps
// testbench top for the ion zone allocator: clock, reset, stimulus and verdict
module tb_ion_zone_allocator;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 13;
    localparam int IDX_W         = iza_pkg::CFG_IDX_W;
    localparam int DATA_W        = iza_pkg::CFG_DATA_W;

    // op_class bits
    localparam logic [2:0] CLS_NONE = 3'b000;
    localparam logic [2:0] CLS_GATE = 3'b001;
    localparam logic [2:0] CLS_COOL = 3'b010;
    localparam logic [2:0] CLS_MEAS = 3'b100;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    iza_pkg::iza_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    iza_pkg::iza_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data  = '0;

    int pending;
    int mismatches;
    int burst_left = 0;
    int cycle_cnt  = 0;

    ion_zone_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iza_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic iza_pkg::iza_in_t mk_cmd(input logic cmd, input logic [2:0] cls,
                                                input logic [1:0] cnt, input logic [3:0] a,
                                                input logic [3:0] b, input logic [3:0] c);
        iza_pkg::iza_in_t w;
        w.command       = cmd;
        w.op_class      = cls;
        w.target_count  = cnt;
        w.first_target  = a;
        w.second_target = b;
        w.third_target  = c;
        mk_cmd = w;
    endfunction

    // mostly targets among the loaded ions, now and then any index
    function automatic logic [3:0] pick_target(input logic [4:0] ic);
        if ($urandom_range(0, 3) != 0)
            pick_target = 4'($urandom_range(0, int'(ic) - 1));
        else
            pick_target = 4'($urandom_range(0, 15));
    endfunction

    function automatic iza_pkg::iza_in_t random_cmd(input logic [4:0] ic);
        iza_pkg::iza_in_t w;
        w.command       = ($urandom_range(0, 9) == 0) ? iza_pkg::CMD_LOAD : iza_pkg::CMD_EXEC;
        w.op_class      = 3'($urandom_range(0, 7));
        w.target_count  = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        w.first_target  = pick_target(ic);
        w.second_target = pick_target(ic);
        w.third_target  = pick_target(ic);
        random_cmd = w;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [3:0] zc, input logic [4:0] ic,
                                 input logic [47:0] zt, input logic [31:0] zcap);
        write_reg(iza_pkg::CFG_ZONE_COUNT, DATA_W'(zc));
        write_reg(iza_pkg::CFG_ION_COUNT, DATA_W'(ic));
        write_reg(iza_pkg::CFG_ZONE_TYPES, DATA_W'(zt));
        write_reg(iza_pkg::CFG_ZONE_CAPS, DATA_W'(zcap));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings(output logic [3:0] zc, output logic [4:0] ic,
                                   output logic [47:0] zt, output logic [31:0] zcap);
        int z;
        int lz;
        int sz;
        zc = 4'($urandom_range(1, 8));
        ic = 5'($urandom_range(1, 16));
        zt = '0;
        zcap = '0;
        for (z = 0; z < 8; z++)
        begin
            zt[6*z +: 6] = 6'($urandom_range(0, 63)
                              & ($urandom_range(0, 63) | $urandom_range(0, 63)));
            zcap[4*z +: 4] = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 6))
                                                        : 4'($urandom_range(0, 15));
        end
        // keep at least one load zone and one place to park ions
        lz = int'($urandom_range(0, int'(zc) - 1));
        sz = int'($urandom_range(0, int'(zc) - 1));
        zt[6*lz +: 6] = zt[6*lz +: 6] | iza_pkg::T_LOAD;
        zt[6*sz +: 6] = zt[6*sz +: 6]
                      | (($urandom_range(0, 1) == 0) ? iza_pkg::T_STORAGE : iza_pkg::T_EMPTY);
        if ($urandom_range(0, 2) == 0)
            zcap[4*lz +: 4] = 4'hF;
    endtask

    // sender works in bursts with random gaps in between
    task automatic offer(input iza_pkg::iza_in_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 99) < 30) ? 0 : int'($urandom_range(1, 6));
            burst_left = int'($urandom_range(1, 10));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // wait until every expected word is back, then let write-back finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall pattern, with two long hold-offs to back up the input
    initial
    begin
        int seg;
        int seg_len;
        int mode;
        int k;
        seg = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (seg == 3 || seg == 11)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg_len = int'($urandom_range(20, 80));
                mode = int'($urandom_range(0, 3));
                for (k = 0; k < seg_len; k++)
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= k[0];
                        default: out_stall <= ($urandom_range(0, 99) < 75);
                    endcase
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_ion_zone_allocator: FAIL");
        $finish;
    end

    initial
    begin
        logic [3:0]  zc;
        logic [4:0]  ic;
        logic [47:0] zt;
        logic [31:0] zcap;
        int          p;
        int          i;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no typed zones at all
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_NONE, 2'd3, 4'd15, 4'd15, 4'd15));
        offer(mk_cmd(iza_pkg::CMD_LOAD, CLS_GATE | CLS_COOL | CLS_MEAS, 2'd3,
                     4'd15, 4'd15, 4'd15));
        drain();

        // at least one zone of each kind
        load_settings(4'd8, 5'd6,
                      {iza_pkg::T_LOAD | iza_pkg::T_EMPTY, iza_pkg::T_GATE | iza_pkg::T_STORAGE,
                       iza_pkg::T_EMPTY, iza_pkg::T_STORAGE, iza_pkg::T_MEASURE,
                       iza_pkg::T_COOL, iza_pkg::T_GATE, iza_pkg::T_LOAD},
                      {4'd4, 4'd1, 4'd1, 4'd3, 4'd1, 4'd2, 4'd2, 4'd4});
        offer(mk_cmd(iza_pkg::CMD_LOAD, CLS_NONE, 2'd0, 4'd0, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd0, 4'd1, 4'd2));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_COOL, 2'd2, 4'd3, 4'd3, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_MEAS, 2'd1, 4'd15, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_NONE, 2'd2, 4'd1, 4'd2, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE | CLS_COOL | CLS_MEAS, 2'd0,
                     4'd0, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_COOL | CLS_MEAS, 2'd1, 4'd4, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd5, 4'd4, 4'd3));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE | CLS_COOL, 2'd3, 4'd0, 4'd1, 4'd2));
        drain();

        // single zone without a gate type: load runs out of room, gate has priority
        load_settings(4'd1, 5'd16,
                      {42'd0, iza_pkg::T_LOAD | iza_pkg::T_COOL | iza_pkg::T_STORAGE},
                      {28'd0, 4'd15});
        offer(mk_cmd(iza_pkg::CMD_LOAD, CLS_NONE, 2'd0, 4'd0, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE | CLS_COOL, 2'd1, 4'd0, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_COOL, 2'd3, 4'd7, 4'd8, 4'd9));
        drain();

        // fill a gate-and-storage zone up to the point where occupancy saturates
        load_settings(4'd4, 5'd16,
                      {24'd0, iza_pkg::T_EMPTY, iza_pkg::T_LOAD, iza_pkg::T_LOAD,
                       iza_pkg::T_GATE | iza_pkg::T_STORAGE},
                      {16'd0, 4'd15, 4'd15, 4'd15, 4'd15});
        offer(mk_cmd(iza_pkg::CMD_LOAD, CLS_NONE, 2'd0, 4'd0, 4'd0, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd0, 4'd1, 4'd2));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd3, 4'd4, 4'd5));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd6, 4'd7, 4'd8));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd9, 4'd10, 4'd11));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd2, 4'd12, 4'd13, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd14, 4'd15, 4'd0));
        offer(mk_cmd(iza_pkg::CMD_EXEC, CLS_GATE, 2'd3, 4'd1, 4'd2, 4'd3));
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                zc = 4'd8;
                ic = 5'd16;
                zt = '1;
                zcap = '1;
            end
            else
            begin
                random_settings(zc, ic, zt, zcap);
                if (p == 1)
                begin
                    zc = 4'd8;
                    ic = 5'd1;
                end
            end
            load_settings(zc, ic, zt, zcap);
            offer(mk_cmd(iza_pkg::CMD_LOAD, CLS_NONE, 2'd0, 4'd0, 4'd0, 4'd0));
            for (i = 1; i < PHASE_ITEMS; i++)
                offer(random_cmd(ic));
            drain();
        end

        @(negedge clk);
        if (mismatches == 0)
            $display("tb_ion_zone_allocator: PASS");
        else
            $display("tb_ion_zone_allocator: FAIL");
        $finish;
    end

endmodule
